// ===== sv/ufar_pkg.sv =====
// Shared constants, phase codes and CRC helpers for the frame acknowledgement responder.
`timescale 1ns / 1ps

package ufar_pkg;

  // Receive parser phases
  localparam logic [3:0] PH_HUNT0   = 4'd0;
  localparam logic [3:0] PH_HUNT1   = 4'd1;
  localparam logic [3:0] PH_CODE_LO = 4'd2;
  localparam logic [3:0] PH_CODE_HI = 4'd3;
  localparam logic [3:0] PH_LEN_LO  = 4'd4;
  localparam logic [3:0] PH_LEN_HI  = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CRC_LO  = 4'd7;
  localparam logic [3:0] PH_CRC_HI  = 4'd8;
  localparam logic [3:0] PH_FOOTER  = 4'd9;

  // Configuration register indexes
  localparam logic [1:0] REG_CODE_FIRST  = 2'd0;
  localparam logic [1:0] REG_CODE_SECOND = 2'd1;
  localparam logic [1:0] REG_STATUS      = 2'd2;

  // Frame framing bytes
  localparam logic [7:0] RX_HDR0    = 8'h90;
  localparam logic [7:0] RX_HDR1    = 8'h40;
  localparam logic [7:0] FOOTER     = 8'hFF;
  localparam logic [7:0] ACK_HDR0   = 8'h81;
  localparam logic [7:0] ACK_HDR1   = 8'hAB;
  localparam logic [7:0] ACK_LEN_LO = 8'h01;
  localparam logic [7:0] ACK_LEN_HI = 8'h00;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [15:0] ACK_FLAG    = 16'h8000;
  localparam logic [15:0] CODE1_RESET = 16'h0120;
  localparam logic [15:0] CODE2_RESET = 16'h0122;

  // Byte positions within the acknowledgement
  localparam logic [3:0] ACK_IDX_FIRST = 4'd0;
  localparam logic [3:0] ACK_IDX_LAST  = 4'd9;

  // Pending acknowledgement record
  typedef struct packed {
    logic [15:0] code;
    logic [7:0]  status;
  } ack_rec_t;

  // CRC-16/MODBUS update by one byte (reflected)
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Acknowledgement byte at a given position
  function automatic logic [7:0] ack_byte(input logic [3:0] idx, input logic [15:0] code,
                                          input logic [7:0] status, input logic [15:0] crc);
    logic [7:0] r;
    case (idx)
      4'd0:    r = ACK_HDR0;
      4'd1:    r = ACK_HDR1;
      4'd2:    r = code[7:0];
      4'd3:    r = code[15:8];
      4'd4:    r = ACK_LEN_LO;
      4'd5:    r = ACK_LEN_HI;
      4'd6:    r = status;
      4'd7:    r = crc[7:0];
      4'd8:    r = crc[15:8];
      default: r = FOOTER;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/uart_frame_ack_responder.sv =====
// Frame parser with CRC-16/MODBUS check and acknowledgement frame generator.
`timescale 1ns / 1ps

// Channel  Dir  Group                     Contents
// in_      in   tvalid/tready/tdata[7:0]  received byte
// out_     out  tvalid/tready/tdata/tlast ack byte, tlast on the tenth byte
// cfg_     in   valid/ready/index/data    code first, code second, status
//
// One received word is parsed per cycle; the CRC step and phase update are one register stage.
// An ack is sent as 10 words at one per cycle from a registered serialiser; one ack may wait
// in a holding slot, and input stalls only while that slot is full.
// Reset (rst_n low, synchronous) returns the parser to header hunt and restores config defaults.
// Output stalls hold the current word; cfg_ready is always high.

module uart_frame_ack_responder
  import ufar_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] tx_byte
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] code1_r, code2_r;
  logic [7:0]  status_r;

  logic [3:0]  phase_r, phase_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic [15:0] evcode_r, evcode_nxt;
  logic [7:0]  len_lo_r, len_lo_nxt;
  logic [15:0] rcrc_r, rcrc_nxt;
  logic [15:0] rxcrc_r, rxcrc_nxt;

  logic        pend_valid_r, pend_valid_nxt;
  ack_rec_t    pend_r, pend_nxt;

  logic        oval_r, oval_nxt;
  logic [7:0]  obyte_r, obyte_nxt;
  logic        olast_r, olast_nxt;
  logic [3:0]  idx_r, idx_nxt;
  ack_rec_t    ser_r, ser_nxt;
  logic [15:0] acrc_r, acrc_nxt;

  logic        in_acc, ack_trig, ser_load;
  logic [7:0]  b;
  logic [15:0] crc_step, remain_dec;

  assign in_tready  = !pend_valid_r;
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = oval_r;
  assign out_tdata  = obyte_r;
  assign out_tlast  = olast_r;
  assign b          = in_tdata;
  assign crc_step   = crc16_byte(rcrc_r, b);
  assign remain_dec = (remain_r != 16'd0) ? remain_r - 16'd1 : 16'd0;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code1_r  <= CODE1_RESET;
      code2_r  <= CODE2_RESET;
      status_r <= 8'h00;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CODE_FIRST:  code1_r  <= cfg_data;
        REG_CODE_SECOND: code2_r  <= cfg_data;
        REG_STATUS:      status_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Receive parser
  always_comb begin
    phase_nxt  = phase_r;
    remain_nxt = remain_r;
    evcode_nxt = evcode_r;
    len_lo_nxt = len_lo_r;
    rcrc_nxt   = rcrc_r;
    rxcrc_nxt  = rxcrc_r;
    ack_trig   = 1'b0;
    if (in_acc) begin
      case (phase_r)
        PH_HUNT1: begin
          if (b == RX_HDR1) begin
            rcrc_nxt  = CRC_INIT;
            phase_nxt = PH_CODE_LO;
          end else begin
            phase_nxt = (b == RX_HDR0) ? PH_HUNT1 : PH_HUNT0;
          end
        end
        PH_CODE_LO: begin
          rcrc_nxt   = crc_step;
          evcode_nxt = {8'h00, b};
          phase_nxt  = PH_CODE_HI;
        end
        PH_CODE_HI: begin
          rcrc_nxt   = crc_step;
          evcode_nxt = {b, evcode_r[7:0]};
          phase_nxt  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          rcrc_nxt   = crc_step;
          len_lo_nxt = b;
          phase_nxt  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          rcrc_nxt   = crc_step;
          remain_nxt = {b, len_lo_r};
          phase_nxt  = ({b, len_lo_r} != 16'd0) ? PH_PAYLOAD : PH_CRC_LO;
        end
        PH_PAYLOAD: begin
          rcrc_nxt   = crc_step;
          remain_nxt = remain_dec;
          if (remain_dec == 16'd0) phase_nxt = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          rxcrc_nxt = {8'h00, b};
          phase_nxt = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          rxcrc_nxt = {b, rxcrc_r[7:0]};
          phase_nxt = PH_FOOTER;
        end
        PH_FOOTER: begin
          if (b == FOOTER) begin
            ack_trig  = (rxcrc_r == rcrc_r) && (evcode_r == code1_r || evcode_r == code2_r);
            phase_nxt = PH_HUNT0;
          end else begin
            phase_nxt = (b == RX_HDR0) ? PH_HUNT1 : PH_HUNT0;
          end
        end
        default: begin
          // hunting the first header byte, and unused phase codes
          phase_nxt = (b == RX_HDR0) ? PH_HUNT1 : PH_HUNT0;
        end
      endcase
    end
  end

  // Holding slot and ack serialiser
  always_comb begin
    ser_load       = pend_valid_r && (!oval_r || (out_tready && olast_r));
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    oval_nxt       = oval_r;
    obyte_nxt      = obyte_r;
    olast_nxt      = olast_r;
    idx_nxt        = idx_r;
    ser_nxt        = ser_r;
    acrc_nxt       = acrc_r;
    if (ack_trig) begin
      pend_valid_nxt = 1'b1;
      pend_nxt.code   = evcode_r | ACK_FLAG;
      pend_nxt.status = status_r;
    end else if (ser_load) begin
      pend_valid_nxt = 1'b0;
    end
    if (ser_load) begin
      oval_nxt  = 1'b1;
      idx_nxt   = ACK_IDX_FIRST;
      ser_nxt   = pend_r;
      acrc_nxt  = CRC_INIT;
      obyte_nxt = ACK_HDR0;
      olast_nxt = 1'b0;
    end else if (oval_r && out_tready) begin
      if (olast_r) begin
        oval_nxt  = 1'b0;
        olast_nxt = 1'b0;
      end else begin
        idx_nxt   = idx_r + 4'd1;
        obyte_nxt = ack_byte(idx_nxt, ser_r.code, ser_r.status, acrc_r);
        olast_nxt = (idx_nxt == ACK_IDX_LAST);
        // CRC runs over code, length and status words as they are loaded
        if (idx_nxt inside {[4'd2:4'd6]}) acrc_nxt = crc16_byte(acrc_r, obyte_nxt);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT0;
      remain_r     <= 16'd0;
      evcode_r     <= 16'd0;
      rcrc_r       <= CRC_INIT;
      rxcrc_r      <= 16'd0;
      pend_valid_r <= 1'b0;
      oval_r       <= 1'b0;
      olast_r      <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      remain_r     <= remain_nxt;
      evcode_r     <= evcode_nxt;
      rcrc_r       <= rcrc_nxt;
      rxcrc_r      <= rxcrc_nxt;
      pend_valid_r <= pend_valid_nxt;
      oval_r       <= oval_nxt;
      olast_r      <= olast_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    len_lo_r <= len_lo_nxt;
    pend_r   <= pend_nxt;
    obyte_r  <= obyte_nxt;
    idx_r    <= idx_nxt;
    ser_r    <= ser_nxt;
    acrc_r   <= acrc_nxt;
  end

  // Checks
  a_trig_fills_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ack_trig |=> pend_valid_r)
    else $error("ack trigger did not reach holding slot");

  a_ack_stays_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (oval_r && out_tready && !olast_r) |=> oval_r)
    else $error("ack frame broken off before last word");

  a_ack_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (oval_r && out_tready && olast_r && !pend_valid_r) |=> !oval_r)
    else $error("output still valid after last ack word");

  a_ack_starts: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(oval_r) |-> (obyte_r == ACK_HDR0 && !olast_r))
    else $error("ack frame did not start with its header");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_FOOTER)
    else $error("parser phase out of range");

endmodule
